// ===== rtl/hlba_pkg.sv =====
// Package for the hardware lock bank allocator.
// Holds sizing constants, opcode and status codes, and the controller/datapath structs.
// No dependencies.
package hlba_pkg;

    localparam int NUM_LOCKS = 1024;
    localparam int IDX_W     = 10;
    localparam int IDX_LIMIT = 1 << IDX_W;
    localparam int USABLE    = (NUM_LOCKS < IDX_LIMIT) ? NUM_LOCKS : IDX_LIMIT;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int NUM_WORDS = (USABLE + WORD_W - 1) / WORD_W;
    localparam int ROW_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_WORDS - 1);

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_TRY    = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK = 2'd2;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BUSY    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_UNALLOC = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             rd_en;
        logic             rd_from_idx;
        logic [ROW_W-1:0] rd_row;
        logic             commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_alloc;
        logic dv;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/hlba_ctrl.sv =====
// Controller state machine for the lock bank allocator.
// Sequences the bitmap scan and single-entry updates; depends on hlba_pkg.
module hlba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  hlba_pkg::t_stat i_stat,
    output hlba_pkg::t_cmd  o_cmd
);
    import hlba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [ROW_W-1:0] r_scan, n_scan;
    logic             r_scan_done, n_scan_done;

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_scan_done = r_scan_done;
        o_cmd       = '0;
        o_cmd.rd_row = r_scan;
        o_s_tready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_scan       = '0;
                    n_scan_done  = 1'b0;
                    // The opcode is only visible to the datapath after this edge,
                    // so decide the path in the next state.
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.is_alloc) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.rd_en       = 1'b1;
                    o_cmd.rd_from_idx = 1'b1;
                    n_state           = S_FIN;
                end
            end
            S_SCAN: begin
                // Stop reading as soon as a word with a free bit, or the last word,
                // has been returned; the read register then holds that word.
                if (i_stat.dv && (i_stat.hit || i_stat.last)) begin
                    n_state = S_FIN;
                end else if (!r_scan_done) begin
                    o_cmd.rd_en = 1'b1;
                    if (r_scan == LAST_ROW) begin
                        n_scan_done = 1'b1;
                    end else begin
                        n_scan = r_scan + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_scan_done <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_scan_done <= n_scan_done;
        end
    end

endmodule

// ===== rtl/hlba_dp.sv =====
// Datapath for the lock bank allocator: bitmap memories, row valid bits,
// free-bit search, entry update and the result register. Depends on hlba_pkg.
module hlba_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [hlba_pkg::OP_W-1:0]  i_opcode,
    input  logic [hlba_pkg::IDX_W-1:0] i_lock_index,
    input  logic                      i_m_tready,
    input  hlba_pkg::t_cmd             i_cmd,
    output hlba_pkg::t_stat            o_stat,
    output logic                      o_out_valid,
    output logic [hlba_pkg::ST_W-1:0]  o_status,
    output logic [hlba_pkg::IDX_W-1:0] o_granted_index
);
    import hlba_pkg::*;

    // One row holds 32 entries; a row never written reads as all clear.
    logic [WORD_W-1:0] mem_alloc [NUM_WORDS];
    logic [WORD_W-1:0] mem_held  [NUM_WORDS];
    logic              r_row_valid [NUM_WORDS];

    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_rd_alloc, r_rd_held;
    logic              r_rd_rv;
    logic [ROW_W-1:0]  r_rd_row_q;
    logic              r_dv;
    logic              r_out_valid;
    logic [ST_W-1:0]   r_out_status;
    logic [IDX_W-1:0]  r_out_granted;

    logic [ROW_W-1:0]  rd_row;
    logic [WORD_W-1:0] cur_alloc, cur_held, usable, free_bits;
    logic [BIT_W-1:0]  first_free, bit_sel;
    logic              hit, in_bank, a_bit, h_bit, wr_need;
    logic [WORD_W-1:0] n_alloc_word, n_held_word, sel_mask;
    logic [ST_W-1:0]   n_status;
    logic [IDX_W-1:0]  n_granted;

    assign rd_row = i_cmd.rd_from_idx ? ROW_W'(r_idx >> BIT_W) : i_cmd.rd_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_opcode;
            r_idx <= i_lock_index;
        end
        if (i_cmd.rd_en) begin
            r_rd_alloc <= mem_alloc[rd_row];
            r_rd_held  <= mem_held[rd_row];
            r_rd_rv    <= r_row_valid[rd_row];
            r_rd_row_q <= rd_row;
        end
        if (i_cmd.commit && wr_need) begin
            mem_alloc[r_rd_row_q] <= n_alloc_word;
            mem_held[r_rd_row_q]  <= n_held_word;
        end
        if (i_cmd.commit) begin
            r_out_status  <= n_status;
            r_out_granted <= n_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < NUM_WORDS; r++) begin
                r_row_valid[r] <= 1'b0;
            end
        end else begin
            r_dv <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit && wr_need) begin
                r_row_valid[r_rd_row_q] <= 1'b1;
            end
        end
    end

    assign cur_alloc = r_rd_rv ? r_rd_alloc : '0;
    assign cur_held  = r_rd_rv ? r_rd_held  : '0;

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            usable[b] = ((int'(r_rd_row_q) * WORD_W + b) < USABLE);
        end
        free_bits  = ~cur_alloc & usable;
        hit        = |free_bits;
        first_free = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                first_free = BIT_W'(b);
            end
        end
    end

    assign in_bank = (int'(r_idx) < USABLE);

    always_comb begin
        bit_sel      = (r_op == OP_ALLOC) ? first_free : r_idx[BIT_W-1:0];
        sel_mask     = WORD_W'(1) << bit_sel;
        a_bit        = cur_alloc[bit_sel];
        h_bit        = cur_held[bit_sel];
        n_alloc_word = cur_alloc;
        n_held_word  = cur_held;
        wr_need      = 1'b0;
        n_status     = ST_OK;
        n_granted    = '0;
        unique case (r_op)
            OP_ALLOC: begin
                if (hit) begin
                    n_alloc_word = cur_alloc | sel_mask;
                    n_held_word  = cur_held & ~sel_mask;
                    wr_need      = 1'b1;
                    n_granted    = IDX_W'({r_rd_row_q, first_free});
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_TRY: begin
                if (!in_bank || !a_bit) begin
                    n_status = ST_UNALLOC;
                end else if (h_bit) begin
                    n_status = ST_BUSY;
                end else begin
                    n_held_word = cur_held | sel_mask;
                    wr_need     = 1'b1;
                end
            end
            OP_UNLOCK: begin
                if (!in_bank || !a_bit) begin
                    n_status = ST_UNALLOC;
                end else begin
                    n_held_word = cur_held & ~sel_mask;
                    wr_need     = 1'b1;
                end
            end
            OP_FREE: begin
                if (in_bank) begin
                    n_alloc_word = cur_alloc & ~sel_mask;
                    n_held_word  = cur_held & ~sel_mask;
                    wr_need      = 1'b1;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    assign o_stat.is_alloc = (r_op == OP_ALLOC);
    assign o_stat.dv       = r_dv;
    assign o_stat.hit      = hit;
    assign o_stat.last     = (r_rd_row_q == LAST_ROW);
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = r_out_granted;

endmodule

// ===== rtl/hardware_lock_bank_allocator_top.sv =====
// Top level of the hardware lock bank allocator.
// Instantiates hlba_ctrl and hlba_dp; depends on hlba_pkg.

// The block serves one request word at a time. Try-lock, unlock and free
// go through acceptance, one bitmap row read and an update per request
// word; the update waits while an earlier reply is still untaken, and the
// reply word is registered when the update commits. Allocate reads the
// allocated bitmap one 32-entry row per cycle until a row with a free
// entry, or the last row, has been returned, then updates the same way.
// Rows never written since reset read as all free, so no clearing pass runs
// after reset. A finished result sits in an output register, and the next
// request word is taken while it waits.
module hardware_lock_bank_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [1:0] opcode, [11:2] lock_index, [15:12] zero
    input  logic [hlba_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] status, [11:2] granted_index, [15:12] zero
    output logic [hlba_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import hlba_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  granted_index;

    hlba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hlba_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_s_tdata[OP_W-1:0]),
        .i_lock_index    (i_s_tdata[OP_W+IDX_W-1:OP_W]),
        .i_m_tready      (i_m_tready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_m_tvalid),
        .o_status        (status),
        .o_granted_index (granted_index)
    );

    assign o_m_tdata = {{(OUT_DATA_W - ST_W - IDX_W){1'b0}}, granted_index, status};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for hardware_lock_bank_allocator_top.
// Drives request words over the input stream, predicts each reply word from a
// local copy of the lock bank, and compares. Depends on hlba_pkg and the RTL.
module tb_top;
    import hlba_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] granted;
    } t_lock_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    hardware_lock_bank_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Local copy of the lock bank.
    bit [USABLE-1:0] bank_allocated = '0;
    bit [USABLE-1:0] bank_held = '0;

    logic [IN_DATA_W-1:0] pending_words[$];
    t_lock_reply          expected_replies[$];

    int  src_idle_pct = 9;
    int  sink_idle_pct = 53;
    int  words_pushed = 0;
    int  words_accepted = 0;
    int  mismatch_count = 0;
    int  grant_ceiling = 0;
    int  full_seen = 0;
    int  status_count[4] = '{0, 0, 0, 0};
    int  hold_requests = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    logic word_taken = 1'b0;

    function automatic t_lock_reply lock_bank_step(logic [OP_W-1:0] op,
                                                   logic [IDX_W-1:0] idx);
        t_lock_reply r;
        logic        in_bank;
        logic        found;
        r.status = ST_OK;
        r.granted = '0;
        in_bank = (int'(idx) < USABLE);
        found = 1'b0;
        case (op)
            OP_ALLOC: begin
                r.status = ST_FULL;
                for (int i = 0; i < USABLE; i++) begin
                    if (!found && !bank_allocated[i]) begin
                        found = 1'b1;
                        bank_allocated[i] = 1'b1;
                        bank_held[i] = 1'b0;
                        r.granted = IDX_W'(i);
                        r.status = ST_OK;
                    end
                end
            end
            OP_TRY: begin
                if (!in_bank || !bank_allocated[idx]) begin
                    r.status = ST_UNALLOC;
                end else if (bank_held[idx]) begin
                    r.status = ST_BUSY;
                end else begin
                    bank_held[idx] = 1'b1;
                end
            end
            OP_UNLOCK: begin
                if (!in_bank || !bank_allocated[idx]) begin
                    r.status = ST_UNALLOC;
                end else begin
                    bank_held[idx] = 1'b0;
                end
            end
            default: begin
                if (in_bank) begin
                    bank_allocated[idx] = 1'b0;
                    bank_held[idx] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < 100) begin
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Request driver: a word stays on the bus until the edge that takes it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= '0;
        end else if (i_s_tvalid && !word_taken) begin
            // Hold the current word.
        end else if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata <= pending_words.pop_front();
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Reply receiver, with an occasional long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= 300;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Monitor: checks reply words, then predicts for the request word taken.
    always @(posedge i_clk) begin : monitor
        t_lock_reply want;
        t_lock_reply got;
        word_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = o_m_tdata[1:0];
            got.granted = o_m_tdata[11:2];
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with nothing outstanding, status", got.status, 0);
            end else begin
                want = expected_replies.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.granted != want.granted)
                    report_mismatch("granted_index", got.granted, want.granted);
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            want = lock_bank_step(i_s_tdata[1:0], i_s_tdata[11:2]);
            expected_replies.push_back(want);
            words_accepted++;
            status_count[want.status]++;
            if (want.status == ST_FULL)
                full_seen++;
            if (i_s_tdata[1:0] == OP_ALLOC && want.status == ST_OK &&
                int'(want.granted) + 1 > grant_ceiling)
                grant_ceiling = int'(want.granted) + 1;
        end
    end

    task automatic push_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
        while (pending_words.size() >= 4) @(posedge i_clk);
        pending_words.push_back({4'b0, idx, op});
        words_pushed++;
    endtask

    task automatic wait_idle();
        while (words_accepted != words_pushed || expected_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Mostly well-formed traffic on entries that are likely allocated, plus noise.
    task automatic issue_mixed(int n);
        int               r;
        int               top;
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            top = (grant_ceiling < USABLE) ? grant_ceiling : USABLE - 1;
            idx = IDX_W'($urandom_range(top));
            if (r < 30) begin
                push_word(OP_ALLOC, IDX_W'($urandom));
            end else if (r < 55) begin
                push_word(OP_TRY, idx);
            end else if (r < 75) begin
                push_word(OP_UNLOCK, idx);
            end else if (r < 86) begin
                push_word(OP_FREE, idx);
            end else if (r < 93) begin
                // Lock, contend, release on one entry.
                push_word(OP_TRY, idx);
                push_word(OP_TRY, idx);
                push_word(OP_UNLOCK, idx);
            end else begin
                push_word(OP_W'($urandom), IDX_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unallocated access, grants in order, contention, release,
        // free of a held entry, and reuse of the lowest free entry.
        push_word(OP_TRY, 10'd0);
        push_word(OP_UNLOCK, 10'd1023);
        push_word(OP_FREE, 10'd1023);
        push_word(OP_ALLOC, 10'd1023);
        push_word(OP_ALLOC, 10'd0);
        push_word(OP_ALLOC, 10'd0);
        push_word(OP_TRY, 10'd1);
        push_word(OP_TRY, 10'd1);
        push_word(OP_UNLOCK, 10'd1);
        push_word(OP_UNLOCK, 10'd1);
        push_word(OP_TRY, 10'd1);
        push_word(OP_FREE, 10'd1);
        push_word(OP_TRY, 10'd1);
        push_word(OP_UNLOCK, 10'd1);
        push_word(OP_ALLOC, 10'd0);
        push_word(OP_FREE, 10'd0);
        push_word(OP_ALLOC, 10'd0);
        push_word(OP_ALLOC, 10'd0);

        issue_mixed(20);
        // Long reply stall while requests keep coming.
        hold_requests++;
        issue_mixed(20);
        wait_idle();

        src_idle_pct = 53;
        sink_idle_pct = 9;
        issue_mixed(30);
        // Fill the bank until allocate reports it full a few times.
        while (full_seen < 3) begin
            if ($urandom_range(63) == 0)
                push_word(OP_TRY, IDX_W'($urandom_range(USABLE - 1)));
            else
                push_word(OP_ALLOC, IDX_W'($urandom));
        end
        push_word(OP_TRY, 10'd1023);
        push_word(OP_TRY, 10'd1023);
        push_word(OP_UNLOCK, 10'd1023);
        wait_idle();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        // Free scattered entries of the full bank and let allocate find them.
        for (int k = 0; k < 8; k++)
            push_word(OP_FREE, IDX_W'($urandom_range(USABLE - 1)));
        for (int k = 0; k < 9; k++)
            push_word(OP_ALLOC, 10'd0);
        issue_mixed(30);

        wait_idle();
        repeat (40) @(negedge i_clk);
        $display("Ran %0d lock requests over three pacing phases, a long reply stall",
                 words_accepted);
        $display("and a full bank: %0d ok, %0d busy, %0d full, %0d not allocated.",
                 status_count[ST_OK], status_count[ST_BUSY], status_count[ST_FULL],
                 status_count[ST_UNALLOC]);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
